// ===== rtl/core/pulse_width_radio_frame_tx_top_assert.svh =====
// Assertion macros for the pulse-width frame transmitter.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef PULSE_WIDTH_RADIO_FRAME_TX_TOP_ASSERT_SVH
`define PULSE_WIDTH_RADIO_FRAME_TX_TOP_ASSERT_SVH

// Same-cycle implication.
`define PWRFT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PWRFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pwrft_pkg.sv =====
`default_nettype none

package pwrft_pkg;

  localparam int unsigned MAX_WORDS = 64;
  localparam int unsigned WORD_BITS = 10;

  localparam logic [10:0] LEAD_IN_TICKS = 11'd250;
  localparam logic [10:0] STOP_TICKS    = 11'd18;
  localparam logic [4:0]  PREAMBLE_BITS = 5'd7;
  localparam logic [4:0]  BITS_PER_WORD = 5'd10;
  localparam logic [9:0]  LEAD_OUT_FALL = 10'd9;
  localparam logic [6:0]  MAX_COUNT     = 7'd64;

  localparam logic [9:0] RST_LEAD_IN_FALL   = 10'd125;
  localparam logic [9:0] RST_PREAMBLE_WIDTH = 10'd18;
  localparam logic [9:0] RST_PREAMBLE_FALL  = 10'd9;
  localparam logic [9:0] RST_STOP_FALL      = 10'd9;
  localparam logic [9:0] RST_BIT_WIDTH      = 10'd18;
  localparam logic [9:0] RST_BIT_SHORT_FALL = 10'd6;
  localparam logic [9:0] RST_BIT_LONG_FALL  = 10'd12;
  localparam logic [9:0] RST_LEAD_OUT_WIDTH = 10'd54;

  typedef enum logic [4:0] {
    PH_LEAD_IN  = 5'b00001,
    PH_PREAMBLE = 5'b00010,
    PH_STOP     = 5'b00100,
    PH_DATA     = 5'b01000,
    PH_LEAD_OUT = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LEAD_IN_FALL   = 3'd0,
    REG_PREAMBLE_WIDTH = 3'd1,
    REG_PREAMBLE_FALL  = 3'd2,
    REG_STOP_FALL      = 3'd3,
    REG_BIT_WIDTH      = 3'd4,
    REG_BIT_SHORT_FALL = 3'd5,
    REG_BIT_LONG_FALL  = 3'd6,
    REG_LEAD_OUT_WIDTH = 3'd7
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/pulse_width_radio_frame_tx_top.sv =====
// Latency: a result is valid in the cycle after its input transaction is accepted.
// Throughput: one item per cycle while item_stall is low; the frame state advances in
// one registered step per item, and the word store read is registered in the background.
// Reset (rst, synchronous): idle, counters zero, internal level low, registers at defaults.
// The word store has no reset and needs no clearing pass; slots are loaded by CMD_LOAD items.
`default_nettype none

module pulse_width_radio_frame_tx_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] command,
  input  wire logic [5:0] word_index,
  input  wire logic [9:0] word_value,
  input  wire logic [6:0] word_count,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic            line_level,
  output logic            message_done,
  output logic            busy_res,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_data
);

  logic [9:0] lead_in_fall, preamble_width, preamble_fall, stop_fall;
  logic [9:0] bit_width, bit_short_fall, bit_long_fall, lead_out_width;

  pwrft_pkg::phase_t phase, phase_next;
  logic [9:0] tick_count, tick_next;
  logic [3:0] bit_count, bit_next;
  logic [5:0] word_pos, pos_next;
  logic [6:0] message_len, len_next;
  logic [9:0] current_word, cw_next;
  logic       sending, sending_next;
  logic       level, level_next;
  logic       done_next;

  logic [9:0] word_store [pwrft_pkg::MAX_WORDS];
  logic [9:0] rd_word;

  logic        accept;
  logic [10:0] tick_inc;
  logic [4:0]  bit_inc;
  logic [6:0]  pos_inc;
  logic        one_bit;
  logic [6:0]  count_sat;

  assign item_stall = res_valid & res_stall;
  assign accept     = item_valid & ~item_stall;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_in_fall   <= pwrft_pkg::RST_LEAD_IN_FALL;
      preamble_width <= pwrft_pkg::RST_PREAMBLE_WIDTH;
      preamble_fall  <= pwrft_pkg::RST_PREAMBLE_FALL;
      stop_fall      <= pwrft_pkg::RST_STOP_FALL;
      bit_width      <= pwrft_pkg::RST_BIT_WIDTH;
      bit_short_fall <= pwrft_pkg::RST_BIT_SHORT_FALL;
      bit_long_fall  <= pwrft_pkg::RST_BIT_LONG_FALL;
      lead_out_width <= pwrft_pkg::RST_LEAD_OUT_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwrft_pkg::REG_LEAD_IN_FALL:   lead_in_fall   <= cfg_data;
        pwrft_pkg::REG_PREAMBLE_WIDTH: preamble_width <= cfg_data;
        pwrft_pkg::REG_PREAMBLE_FALL:  preamble_fall  <= cfg_data;
        pwrft_pkg::REG_STOP_FALL:      stop_fall      <= cfg_data;
        pwrft_pkg::REG_BIT_WIDTH:      bit_width      <= cfg_data;
        pwrft_pkg::REG_BIT_SHORT_FALL: bit_short_fall <= cfg_data;
        pwrft_pkg::REG_BIT_LONG_FALL:  bit_long_fall  <= cfg_data;
        pwrft_pkg::REG_LEAD_OUT_WIDTH: lead_out_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // Word store: loads only while idle; the read tracks word_pos every cycle,
  // which settles long before a stop pulse ends.
  always_ff @(posedge clk) begin
    if (accept && command == pwrft_pkg::CMD_LOAD && !sending) begin
      word_store[word_index] <= word_value;
    end
    rd_word <= word_store[word_pos];
  end

  always_comb begin
    phase_next   = phase;
    tick_next    = tick_count;
    bit_next     = bit_count;
    pos_next     = word_pos;
    len_next     = message_len;
    cw_next      = current_word;
    sending_next = sending;
    level_next   = level;
    done_next    = 1'b0;

    tick_inc = {1'b0, tick_count} + 11'd1;
    bit_inc  = {1'b0, bit_count} + 5'd1;
    pos_inc  = {1'b0, word_pos} + 7'd1;
    one_bit  = ({1'b0, bit_count} < pwrft_pkg::BITS_PER_WORD) ? current_word[bit_count]
                                                               : 1'b0;

    if (word_count == 7'd0) begin
      count_sat = 7'd1;
    end else if (word_count > pwrft_pkg::MAX_COUNT) begin
      count_sat = pwrft_pkg::MAX_COUNT;
    end else begin
      count_sat = word_count;
    end

    if (accept) begin
      case (command)
        pwrft_pkg::CMD_START: begin
          if (!sending) begin
            len_next     = count_sat;
            phase_next   = pwrft_pkg::PH_LEAD_IN;
            tick_next    = '0;
            bit_next     = '0;
            pos_next     = '0;
            sending_next = 1'b1;
          end
        end
        pwrft_pkg::CMD_TICK: begin
          if (sending) begin
            unique case (phase)
              pwrft_pkg::PH_LEAD_IN: begin
                level_next = tick_count < lead_in_fall;
                if (tick_inc >= pwrft_pkg::LEAD_IN_TICKS) begin
                  tick_next  = '0;
                  phase_next = pwrft_pkg::PH_PREAMBLE;
                end else begin
                  tick_next = tick_inc[9:0];
                end
              end
              pwrft_pkg::PH_PREAMBLE: begin
                level_next = tick_count < preamble_fall;
                if (tick_inc >= {1'b0, preamble_width}) begin
                  tick_next = '0;
                  if (bit_inc >= pwrft_pkg::PREAMBLE_BITS) begin
                    bit_next   = '0;
                    phase_next = pwrft_pkg::PH_STOP;
                  end else begin
                    bit_next = bit_inc[3:0];
                  end
                end else begin
                  tick_next = tick_inc[9:0];
                end
              end
              pwrft_pkg::PH_STOP: begin
                level_next = tick_count < stop_fall;
                if (tick_inc >= pwrft_pkg::STOP_TICKS) begin
                  tick_next  = '0;
                  phase_next = pwrft_pkg::PH_DATA;
                  cw_next    = rd_word;
                end else begin
                  tick_next = tick_inc[9:0];
                end
              end
              pwrft_pkg::PH_DATA: begin
                // zero bit: long pulse, one bit: short pulse
                level_next = (tick_count < bit_short_fall) ||
                             ((tick_count < bit_long_fall) && !one_bit);
                if (tick_inc >= {1'b0, bit_width}) begin
                  tick_next = '0;
                  if (bit_inc >= pwrft_pkg::BITS_PER_WORD) begin
                    bit_next = '0;
                    if (pos_inc >= message_len) begin
                      pos_next   = '0;
                      phase_next = pwrft_pkg::PH_LEAD_OUT;
                    end else begin
                      pos_next   = pos_inc[5:0];
                      phase_next = pwrft_pkg::PH_STOP;
                    end
                  end else begin
                    bit_next = bit_inc[3:0];
                  end
                end else begin
                  tick_next = tick_inc[9:0];
                end
              end
              pwrft_pkg::PH_LEAD_OUT: begin
                level_next = tick_count < pwrft_pkg::LEAD_OUT_FALL;
                if (tick_inc >= {1'b0, lead_out_width}) begin
                  phase_next   = pwrft_pkg::PH_LEAD_IN;
                  tick_next    = '0;
                  bit_next     = '0;
                  pos_next     = '0;
                  sending_next = 1'b0;
                  level_next   = 1'b0;
                  done_next    = 1'b1;
                end else begin
                  tick_next = tick_inc[9:0];
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pwrft_pkg::PH_LEAD_IN;
      tick_count   <= '0;
      bit_count    <= '0;
      word_pos     <= '0;
      message_len  <= '0;
      current_word <= '0;
      sending      <= 1'b0;
      level        <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      tick_count   <= tick_next;
      bit_count    <= bit_next;
      word_pos     <= pos_next;
      message_len  <= len_next;
      current_word <= cw_next;
      sending      <= sending_next;
      level        <= level_next;
      res_valid    <= accept | (res_valid & res_stall);
    end
  end

  // Result register, loaded on every accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      line_level   <= level_next;
      message_done <= done_next;
      busy_res     <= sending_next;
    end
  end

`include "pulse_width_radio_frame_tx_top_assert.svh"

  `PWRFT_ASSERT_NEXT(a_result_follows, accept, res_valid, "no result after accepted item")
  `PWRFT_ASSERT_SAME(a_done_idle, res_valid && message_done, !busy_res && !line_level,
                     "done reported while busy or line high")
  `PWRFT_ASSERT_SAME(a_idle_cleared, !sending,
                     phase == pwrft_pkg::PH_LEAD_IN && tick_count == '0 && word_pos == '0,
                     "idle with frame counters not cleared")
  `PWRFT_ASSERT_SAME(a_bit_range, sending && phase == pwrft_pkg::PH_DATA,
                     {1'b0, bit_count} < pwrft_pkg::BITS_PER_WORD,
                     "data bit index out of range")

endmodule

`default_nettype wire
